/* design/bgi_pkg.sv */
// Package for the bilinear grid interpolator: sizes, payload structs,
// register codes and the queue entry type. No dependencies.
`default_nettype none
package bgi_pkg;

    localparam int MAX_LINES   = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int FRAC_BITS   = 16;
    localparam int POS_FRAC    = 32;

    localparam int NODE_W  = 6;
    localparam int CNT_W   = 7;
    localparam int VAL_W   = 32;
    localparam int BANK_AW = 2 * NODE_W - 2;
    localparam int BANK_D  = 1 << BANK_AW;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int PROD_W  = VAL_W + WGT_W + 1;
    localparam int ADDR_W  = 5;

    localparam logic [CNT_W-1:0] LINES_CAP   = CNT_W'(MAX_LINES);
    localparam logic [CNT_W-1:0] COLUMNS_CAP = CNT_W'(MAX_COLUMNS);

    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_INV_X        = 3'd2,
        REG_INV_Y        = 3'd3,
        REG_GRID_LINES   = 3'd4,
        REG_GRID_COLUMNS = 3'd5
    } bgi_reg_t;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_QUERY  = 1'b1
    } bgi_req_t;

    typedef struct packed {
        logic                    req_type;
        logic [NODE_W-1:0]       node_x;
        logic [NODE_W-1:0]       node_y;
        logic signed [VAL_W-1:0] node_value;
        logic signed [VAL_W-1:0] point_x;
        logic signed [VAL_W-1:0] point_y;
    } bgi_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] field_value;
        logic                    out_of_range;
    } bgi_result_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] origin_x;
        logic signed [VAL_W-1:0] origin_y;
        logic [VAL_W-1:0]        inv_x;
        logic [VAL_W-1:0]        inv_y;
        logic [CNT_W-1:0]        lines;
        logic [CNT_W-1:0]        columns;
    } bgi_cfg_t;

    typedef struct packed {
        logic                    req_type;
        logic [NODE_W-1:0]       node_x;
        logic [NODE_W-1:0]       node_y;
        logic signed [VAL_W-1:0] node_value;
        logic [VAL_W-1:0]        mag_x;
        logic                    neg_x;
        logic [VAL_W-1:0]        mag_y;
        logic                    neg_y;
    } bgi_item_t;

endpackage
`default_nettype wire

/* design/bgi_front.sv */
// Front end: takes commands and reduces query points to origin offsets.
// Depends on bgi_pkg.
`default_nettype none
module bgi_front import bgi_pkg::*;
(
    input  wire logic      start,
    input  wire bgi_cmd_t  cmd,
    input  wire bgi_cfg_t  cfg,
    input  wire logic      full,
    output logic           push,
    output bgi_item_t      item
);

    logic signed [VAL_W:0] off_x;
    logic signed [VAL_W:0] off_y;
    logic [VAL_W:0]        neg_off_x;
    logic [VAL_W:0]        neg_off_y;

    always_comb
    begin
        off_x     = {cmd.point_x[VAL_W-1], cmd.point_x} - {cfg.origin_x[VAL_W-1], cfg.origin_x};
        off_y     = {cmd.point_y[VAL_W-1], cmd.point_y} - {cfg.origin_y[VAL_W-1], cfg.origin_y};
        neg_off_x = -off_x;
        neg_off_y = -off_y;

        push            = start && !full;
        item.req_type   = cmd.req_type;
        item.node_x     = cmd.node_x;
        item.node_y     = cmd.node_y;
        item.node_value = cmd.node_value;
        item.neg_x      = off_x[VAL_W];
        item.neg_y      = off_y[VAL_W];
        item.mag_x      = off_x[VAL_W] ? neg_off_x[VAL_W-1:0] : off_x[VAL_W-1:0];
        item.mag_y      = off_y[VAL_W] ? neg_off_y[VAL_W-1:0] : off_y[VAL_W-1:0];
    end

endmodule
`default_nettype wire

/* design/bgi_queue.sv */
// Two-entry queue between front end and back end.
// Depends on bgi_pkg.
`default_nettype none
module bgi_queue import bgi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire bgi_item_t push_item,
    output logic           full,
    output logic           pop,
    output bgi_item_t      pop_item
);

    bgi_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full       = count_reg == 2'd2;
        pop        = count_reg != 2'd0;
        pop_item   = entry_reg[rd_ptr_reg];
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

/* design/bgi_back.sv */
// Back end: scaling, range check, banked node store and the two blend passes.
// Depends on bgi_pkg.
`default_nettype none
module bgi_back import bgi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pop,
    input  wire bgi_item_t pop_item,
    input  wire bgi_cfg_t  cfg,
    output logic           done,
    output bgi_result_t    result
);

    localparam logic [WGT_W-1:0]  ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W:0]   HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

    // stage 1: scaled positions
    logic                    v1_reg;
    bgi_item_t               it1_reg;
    logic [2*VAL_W-1:0]      posx1_reg;
    logic [2*VAL_W-1:0]      posy1_reg;

    // stage 2 logic: locate and store access
    logic [CNT_W-1:0]        nl;
    logic [CNT_W-1:0]        nc;
    logic [VAL_W-1:0]        idx_x;
    logic [VAL_W-1:0]        idx_y;
    logic                    oor_x;
    logic                    oor_y;
    logic                    oor_w;
    logic                    is_query;
    logic                    oor2;
    logic                    we;
    logic [NODE_W-1:0]       cx;
    logic [NODE_W-1:0]       cy;
    logic [1:0]              wbank;
    logic [BANK_AW-1:0]      waddr;

    // stage 3: corners read
    logic                    v3_reg;
    logic                    ok3_reg;
    logic                    oor3_reg;
    logic [FRAC_BITS-1:0]    fx3_reg;
    logic [FRAC_BITS-1:0]    fy3_reg;
    logic                    cx0_reg;
    logic                    cy0_reg;
    logic [VAL_W-1:0]        rd_reg [4];
    logic signed [VAL_W-1:0] c00, c10, c01, c11;
    logic signed [WGT_W:0]   wx0, wx1;

    // stage 4: x products
    logic                    v4_reg;
    logic                    ok4_reg;
    logic                    oor4_reg;
    logic [FRAC_BITS-1:0]    fy4_reg;
    logic signed [PROD_W-1:0] p00_reg, p10_reg, p01_reg, p11_reg;
    logic signed [PROD_W:0]  s_lo, s_hi;

    // stage 5: x blends
    logic                    v5_reg;
    logic                    ok5_reg;
    logic                    oor5_reg;
    logic [FRAC_BITS-1:0]    fy5_reg;
    logic signed [VAL_W-1:0] lo5_reg, hi5_reg;
    logic signed [WGT_W:0]   wy0, wy1;

    // stage 6: y products
    logic                    v6_reg;
    logic                    ok6_reg;
    logic                    oor6_reg;
    logic signed [PROD_W-1:0] q0_reg, q1_reg;
    logic signed [PROD_W:0]  s_r;
    logic signed [PROD_W-FRAC_BITS:0] r_wide;
    logic signed [VAL_W-1:0] r_sat;

    logic                    done_reg;
    bgi_result_t             result_reg;

    always_ff @(posedge clk)
    begin
        it1_reg   <= pop_item;
        posx1_reg <= pop_item.mag_x * cfg.inv_x;
        posy1_reg <= pop_item.mag_y * cfg.inv_y;
    end

    always_comb
    begin
        nl    = (cfg.lines > LINES_CAP) ? LINES_CAP : cfg.lines;
        nc    = (cfg.columns > COLUMNS_CAP) ? COLUMNS_CAP : cfg.columns;
        idx_x = posx1_reg[2*VAL_W-1:POS_FRAC];
        idx_y = posy1_reg[2*VAL_W-1:POS_FRAC];
        oor_x = (it1_reg.neg_x && posx1_reg != '0) || nl < CNT_W'(2)
                || idx_x > VAL_W'(nl - CNT_W'(2));
        oor_y = (it1_reg.neg_y && posy1_reg != '0) || nc < CNT_W'(2)
                || idx_y > VAL_W'(nc - CNT_W'(2));
        oor_w = CNT_W'(it1_reg.node_x) >= nl || CNT_W'(it1_reg.node_y) >= nc;
        is_query = it1_reg.req_type == REQ_QUERY;
        oor2  = is_query ? (oor_x || oor_y) : oor_w;
        we    = v1_reg && !is_query && !oor_w;
        cx    = idx_x[NODE_W-1:0];
        cy    = idx_y[NODE_W-1:0];
        wbank = {it1_reg.node_y[0], it1_reg.node_x[0]};
        waddr = {it1_reg.node_y[NODE_W-1:1], it1_reg.node_x[NODE_W-1:1]};
    end

    // node (x, y) lives in bank {y[0], x[0]}; the four corners hit four banks
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK_SEL = 2'(b);

        logic [VAL_W-1:0]   mem [BANK_D];
        logic [NODE_W-1:0]  xa;
        logic [NODE_W-1:0]  ya;
        logic [BANK_AW-1:0] raddr;

        always_comb
        begin
            xa    = (cx[0] == BANK_SEL[0]) ? cx : cx + NODE_W'(1);
            ya    = (cy[0] == BANK_SEL[1]) ? cy : cy + NODE_W'(1);
            raddr = {ya[NODE_W-1:1], xa[NODE_W-1:1]};
        end

        always_ff @(posedge clk)
        begin
            if (we && wbank == BANK_SEL)
                mem[waddr] <= it1_reg.node_value;
            rd_reg[b] <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        ok3_reg  <= is_query && !oor2;
        oor3_reg <= oor2;
        fx3_reg  <= posx1_reg[POS_FRAC-1 -: FRAC_BITS];
        fy3_reg  <= posy1_reg[POS_FRAC-1 -: FRAC_BITS];
        cx0_reg  <= cx[0];
        cy0_reg  <= cy[0];
    end

    always_comb
    begin
        c00 = rd_reg[{cy0_reg, cx0_reg}];
        c10 = rd_reg[{cy0_reg, ~cx0_reg}];
        c01 = rd_reg[{~cy0_reg, cx0_reg}];
        c11 = rd_reg[{~cy0_reg, ~cx0_reg}];
        wx1 = {2'b00, fx3_reg};
        wx0 = {1'b0, ONE - {1'b0, fx3_reg}};
    end

    always_ff @(posedge clk)
    begin
        ok4_reg  <= ok3_reg;
        oor4_reg <= oor3_reg;
        fy4_reg  <= fy3_reg;
        p00_reg  <= c00 * wx0;
        p10_reg  <= c10 * wx1;
        p01_reg  <= c01 * wx0;
        p11_reg  <= c11 * wx1;
    end

    always_comb
    begin
        s_lo = {p00_reg[PROD_W-1], p00_reg} + {p10_reg[PROD_W-1], p10_reg} + $signed(HALF);
        s_hi = {p01_reg[PROD_W-1], p01_reg} + {p11_reg[PROD_W-1], p11_reg} + $signed(HALF);
    end

    always_ff @(posedge clk)
    begin
        ok5_reg  <= ok4_reg;
        oor5_reg <= oor4_reg;
        fy5_reg  <= fy4_reg;
        lo5_reg  <= s_lo[FRAC_BITS+VAL_W-1:FRAC_BITS];
        hi5_reg  <= s_hi[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end

    always_comb
    begin
        wy1 = {2'b00, fy5_reg};
        wy0 = {1'b0, ONE - {1'b0, fy5_reg}};
    end

    always_ff @(posedge clk)
    begin
        ok6_reg  <= ok5_reg;
        oor6_reg <= oor5_reg;
        q0_reg   <= lo5_reg * wy0;
        q1_reg   <= hi5_reg * wy1;
    end

    always_comb
    begin
        s_r    = {q0_reg[PROD_W-1], q0_reg} + {q1_reg[PROD_W-1], q1_reg} + $signed(HALF);
        r_wide = s_r[PROD_W:FRAC_BITS];
        if (r_wide > $signed((PROD_W-FRAC_BITS+1)'(32'sh7fffffff)))
            r_sat = 32'sh7fffffff;
        else if (r_wide < -$signed((PROD_W-FRAC_BITS+1)'(33'sh080000000)))
            r_sat = 32'sh80000000;
        else
            r_sat = r_wide[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg.field_value  <= ok6_reg ? r_sat : '0;
        result_reg.out_of_range <= oor6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= pop;
            v3_reg   <= v1_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* design/bilinear_grid_interpolator.sv */
// Bilinear grid interpolator: one command per cycle, one result per command;
// done rises once the command has passed one queue slot, then scale, store
// read, x products, x blends, y products and the output register; the back
// end never stalls, so the result strobe cannot be held off and busy stays
// low in use. Node writes and queries keep their order: a query sees every
// earlier write. The node store is four banks split by node index parity, so
// one query reads all four corners in the same cycle. Depends on bgi_pkg and
// submodules.
`default_nettype none
module bilinear_grid_interpolator import bgi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bgi_cmd_t          cmd,
    output logic                   done,
    output bgi_result_t            result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    bgi_cfg_t  cfg_reg;
    bgi_reg_t  reg_idx;
    logic      cfg_we;
    logic      full;
    logic      push;
    logic      pop;
    bgi_item_t push_item;
    bgi_item_t pop_item;

    always_comb
    begin
        reg_idx = bgi_reg_t'(paddr[ADDR_W-1:2]);
        cfg_we  = psel && penable && pwrite;
        pready  = 1'b1;
        case (reg_idx)
            REG_ORIGIN_X:     prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:     prdata = cfg_reg.origin_y;
            REG_INV_X:        prdata = cfg_reg.inv_x;
            REG_INV_Y:        prdata = cfg_reg.inv_y;
            REG_GRID_LINES:   prdata = 32'(cfg_reg.lines);
            REG_GRID_COLUMNS: prdata = 32'(cfg_reg.columns);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.inv_x    <= 32'd65536;
            cfg_reg.inv_y    <= 32'd65536;
            cfg_reg.lines    <= CNT_W'(2);
            cfg_reg.columns  <= CNT_W'(2);
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_ORIGIN_X:     cfg_reg.origin_x <= pwdata;
                REG_ORIGIN_Y:     cfg_reg.origin_y <= pwdata;
                REG_INV_X:        cfg_reg.inv_x    <= pwdata;
                REG_INV_Y:        cfg_reg.inv_y    <= pwdata;
                REG_GRID_LINES:   cfg_reg.lines    <= pwdata[CNT_W-1:0];
                REG_GRID_COLUMNS: cfg_reg.columns  <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy = full;

    bgi_front u_front
    (
        .start (start),
        .cmd   (cmd),
        .cfg   (cfg_reg),
        .full  (full),
        .push  (push),
        .item  (push_item)
    );

    bgi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    bgi_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_item (pop_item),
        .cfg      (cfg_reg),
        .done     (done),
        .result   (result)
    );

endmodule
`default_nettype wire
